/* rtl/psrl_pkg.sv */
`timescale 1ns / 1ps

package psrl_pkg;

   // table geometry
   localparam int SETS  = 1024;
   localparam int WAYS  = 4;
   localparam int SET_W = $clog2(SETS);
   localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;
   localparam int IP_W  = 32;
   localparam int TAG_W = IP_W - SET_W;
   localparam int CNT_W = 8;
   localparam int SEC_W = 16;
   localparam int LIM_W = CNT_W + 1;

   localparam logic [CNT_W-1:0] CNT_MAX = 8'd255;
   localparam logic [SEC_W-1:0] SEC_MAX = 16'hFFFF;

   // register reset values
   localparam logic [7:0]  POST_BASE_RST      = 8'd2;
   localparam logic [4:0]  POST_SHIFT_RST     = 5'd7;
   localparam logic [7:0]  COMMENT_BASE_RST   = 8'd4;
   localparam logic [4:0]  COMMENT_SHIFT_RST  = 5'd6;
   localparam logic [2:0]  MESSAGE_LIMIT_RST  = 3'd5;
   localparam logic [15:0] WINDOW_SECONDS_RST = 16'd300;

   // register indexes
   localparam logic [2:0] CSR_POST_BASE      = 3'd0;
   localparam logic [2:0] CSR_POST_SHIFT     = 3'd1;
   localparam logic [2:0] CSR_COMMENT_BASE   = 3'd2;
   localparam logic [2:0] CSR_COMMENT_SHIFT  = 3'd3;
   localparam logic [2:0] CSR_MESSAGE_LIMIT  = 3'd4;
   localparam logic [2:0] CSR_WINDOW_SECONDS = 3'd5;

   typedef enum logic [1:0] {
      KIND_POST    = 2'd0,
      KIND_COMMENT = 2'd1,
      KIND_MESSAGE = 2'd2,
      KIND_TICK    = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      ST_CLEAR  = 2'd0,
      ST_IDLE   = 2'd1,
      ST_LOOKUP = 2'd2,
      ST_UPDATE = 2'd3
   } state_type;

   typedef struct packed {
      logic                 valid;
      logic [TAG_W-1:0]     tag;
      logic [2:0][CNT_W-1:0] cnt;
   } entry_type;

   typedef entry_type [WAYS-1:0] row_type;

   // controller to datapath
   typedef struct packed {
      logic             capture;
      logic             lookup;
      logic             commit;
      logic             sweep;
      logic [SET_W-1:0] sweep_addr;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic out_busy;
      logic tick_clear;
   } sts_type;

endpackage

/* rtl/psrl_ctrl.sv */
`timescale 1ns / 1ps

module psrl_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   output psrl_pkg::cmd_type cmd,
   input  psrl_pkg::sts_type sts
);
   import psrl_pkg::*;

   state_type        state_ff, state_in;
   logic [SET_W-1:0] clr_ff, clr_in;
   logic             clr_last;

   assign clr_last = (clr_ff == SET_W'(SETS - 1));

   // state and sweep counter registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff   <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR:  if (clr_last) state_in = ST_IDLE;
         ST_IDLE:   if (req_tvalid) state_in = ST_LOOKUP;
         ST_LOOKUP: state_in = ST_UPDATE;
         ST_UPDATE: begin
            if (!sts.out_busy) state_in = sts.tick_clear ? ST_CLEAR : ST_IDLE;
         end
         default:   state_in = ST_CLEAR;
      endcase
   end

   // outputs
   always_comb begin
      req_tready     = 1'b0;
      cmd            = '0;
      cmd.sweep_addr = clr_ff;
      clr_in         = '0;
      case (state_ff)
         ST_CLEAR: begin
            cmd.sweep = 1'b1;
            clr_in    = clr_ff + 1'b1;
         end
         ST_IDLE: begin
            req_tready  = 1'b1;
            cmd.capture = req_tvalid;
         end
         ST_LOOKUP: cmd.lookup = 1'b1;
         ST_UPDATE: cmd.commit = !sts.out_busy;
         default:   cmd = '0;
      endcase
   end

endmodule

/* rtl/psrl_datapath.sv */
`timescale 1ns / 1ps

module psrl_datapath (
   input  logic              clock,
   input  logic              reset,
   input  psrl_pkg::cmd_type cmd,
   output psrl_pkg::sts_type sts,
   input  logic [1:0]        req_tuser,
   input  logic [63:0]       req_tdata,
   input  logic              csr_valid,
   input  logic [2:0]        csr_index,
   input  logic [15:0]       csr_data,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [7:0]        rsp_tdata
);
   import psrl_pkg::*;

   // configuration registers
   logic [7:0]  post_base_ff, comment_base_ff;
   logic [4:0]  post_shift_ff, comment_shift_ff;
   logic [2:0]  message_limit_ff;
   logic [15:0] window_seconds_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         post_base_ff      <= POST_BASE_RST;
         post_shift_ff     <= POST_SHIFT_RST;
         comment_base_ff   <= COMMENT_BASE_RST;
         comment_shift_ff  <= COMMENT_SHIFT_RST;
         message_limit_ff  <= MESSAGE_LIMIT_RST;
         window_seconds_ff <= WINDOW_SECONDS_RST;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_POST_BASE:      post_base_ff      <= csr_data[7:0];
            CSR_POST_SHIFT:     post_shift_ff     <= csr_data[4:0];
            CSR_COMMENT_BASE:   comment_base_ff   <= csr_data[7:0];
            CSR_COMMENT_SHIFT:  comment_shift_ff  <= csr_data[4:0];
            CSR_MESSAGE_LIMIT:  message_limit_ff  <= csr_data[2:0];
            CSR_WINDOW_SECONDS: window_seconds_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // captured transaction
   kind_type          kind_ff;
   logic [SET_W-1:0]  set_ff;
   logic [TAG_W-1:0]  tag_ff;
   logic [31:0]       score_ff;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         kind_ff  <= kind_type'(req_tuser);
         set_ff   <= req_tdata[SET_W-1:0];
         tag_ff   <= req_tdata[IP_W-1:SET_W];
         score_ff <= req_tdata[63:32];
      end
   end

   // allowance: base plus score / 2^shift toward zero, clamped to 0..256; messages use the message limit
   logic [7:0]       base_sel;
   logic [4:0]       shift_sel;
   logic [31:0]      round_mask, score_adj, score_q;
   logic [33:0]      allow_sum;
   logic [LIM_W-1:0] lim_in, lim_ff;

   always_comb begin
      base_sel   = (kind_ff == KIND_POST) ? post_base_ff : comment_base_ff;
      shift_sel  = (kind_ff == KIND_POST) ? post_shift_ff : comment_shift_ff;
      round_mask = ~(32'hFFFF_FFFF << shift_sel);
      score_adj  = score_ff + (score_ff[31] ? round_mask : 32'd0);
      score_q    = 32'($signed(score_adj) >>> shift_sel);
      allow_sum  = {{2{score_q[31]}}, score_q} + {26'd0, base_sel};
      if (kind_ff == KIND_MESSAGE) begin
         lim_in = {6'd0, message_limit_ff};
      end else if (allow_sum[33]) begin
         lim_in = '0;
      end else if (allow_sum[32:0] > 33'd256) begin
         lim_in = 9'd256;
      end else begin
         lim_in = allow_sum[LIM_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.lookup) lim_ff <= lim_in;
   end

   // set memory, one row of all ways per set
   row_type mem [SETS];
   row_type rd_ff;
   logic    mem_we;
   logic [SET_W-1:0] mem_waddr;
   row_type mem_wdata;
   row_type new_row;

   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_waddr] <= mem_wdata;
      if (cmd.lookup) rd_ff <= mem[set_ff];
   end

   // way match, allocation and counter update
   logic             hit_any, free_any, table_full, over;
   logic [WAY_W-1:0] hit_way, free_way, sel_way;
   entry_type        sel_entry, new_entry;
   logic [CNT_W-1:0] cnt_cur, cnt_next;

   always_comb begin
      hit_any  = 1'b0;
      hit_way  = '0;
      free_any = 1'b0;
      free_way = '0;
      for (int w = WAYS - 1; w >= 0; w--) begin
         if (!rd_ff[w].valid) begin
            free_any = 1'b1;
            free_way = WAY_W'(w);
         end
      end
      for (int w = 0; w < WAYS; w++) begin
         if (rd_ff[w].valid && rd_ff[w].tag == tag_ff) begin
            hit_any = 1'b1;
            hit_way = WAY_W'(w);
         end
      end
      sel_way = hit_any ? hit_way : free_way;
      if (hit_any) begin
         sel_entry = rd_ff[hit_way];
      end else begin
         sel_entry.valid = 1'b1;
         sel_entry.tag   = tag_ff;
         sel_entry.cnt   = '0;
      end
      case (kind_ff)
         KIND_POST:    cnt_cur = sel_entry.cnt[0];
         KIND_COMMENT: cnt_cur = sel_entry.cnt[1];
         KIND_MESSAGE: cnt_cur = sel_entry.cnt[2];
         default:      cnt_cur = '0;
      endcase
      over     = ({1'b0, cnt_cur} >= lim_ff);
      cnt_next = (over || cnt_cur == CNT_MAX) ? cnt_cur : cnt_cur + 1'b1;
      new_entry = sel_entry;
      case (kind_ff)
         KIND_POST:    new_entry.cnt[0] = cnt_next;
         KIND_COMMENT: new_entry.cnt[1] = cnt_next;
         KIND_MESSAGE: new_entry.cnt[2] = cnt_next;
         default:      new_entry = sel_entry;
      endcase
      new_row          = rd_ff;
      new_row[sel_way] = new_entry;
      table_full       = !hit_any && !free_any;
   end

   // memory write select: sweep or request write-back
   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = set_ff;
      mem_wdata = new_row;
      if (cmd.sweep) begin
         mem_we    = 1'b1;
         mem_waddr = cmd.sweep_addr;
         mem_wdata = '0;
      end else if (cmd.commit && kind_ff != KIND_TICK && !table_full) begin
         mem_we = 1'b1;
      end
   end

   // window second counter
   logic [SEC_W-1:0] sec_ff, sec_inc;
   logic             window_done;

   assign sec_inc     = (sec_ff == SEC_MAX) ? sec_ff : sec_ff + 1'b1;
   assign window_done = (sec_inc >= window_seconds_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         sec_ff <= '0;
      end else if (cmd.commit && kind_ff == KIND_TICK) begin
         sec_ff <= window_done ? '0 : sec_inc;
      end
   end

   // result register
   logic       rsp_valid_ff;
   logic [2:0] rsp_bits_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.commit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         if (kind_ff == KIND_TICK) begin
            rsp_bits_ff <= {window_done, 1'b0, 1'b0};
         end else begin
            rsp_bits_ff <= {1'b0, table_full, table_full || over};
         end
      end
   end

   assign rsp_tvalid     = rsp_valid_ff;
   assign rsp_tdata      = {5'd0, rsp_bits_ff};
   assign sts.out_busy   = rsp_valid_ff && !rsp_tready;
   assign sts.tick_clear = (kind_ff == KIND_TICK) && window_done;

endmodule

/* rtl/per_source_rate_limiter.sv */
`timescale 1ns / 1ps

// a transaction is accepted in the idle state, its set row is read in the lookup
// state and the result is registered in the update state, which holds while an
// earlier result still waits on rsp_tready; no new transaction is taken before
// the update state commits; a tick that closes the window adds a sweep of all
// SETS (1024) sets; reset: synchronous, active high; after reset the table is swept
// with req_tready low, configuration writes are taken throughout

module per_source_rate_limiter (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,  // [31:0] source_ip, [63:32] score
   input  logic [1:0]  req_tuser,  // [1:0] kind
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,  // [0] limited, [1] table_full, [2] cleared
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_data
);
   import psrl_pkg::*;

   cmd_type cmd;
   sts_type sts;

   assign csr_ready = 1'b1;

   psrl_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .cmd        (cmd),
      .sts        (sts)
   );

   psrl_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .csr_valid  (csr_valid && csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // no transaction taken while the table sweep runs
   a_no_accept_in_sweep: assert property (@(posedge clock) disable iff (reset)
      cmd.sweep |-> !req_tready)
      else $error("request accepted during table sweep");

   // one item in flight at a time
   a_single_item: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready ##1 cmd.commit || !req_tready)
      else $error("second item accepted while one is in flight");

   // a result is never loaded over one still waiting
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> !(rsp_tvalid && !rsp_tready))
      else $error("result overwritten before it was taken");

   // a row read is followed by neither request ready nor a sweep
   a_lookup_then_update: assert property (@(posedge clock) disable iff (reset)
      cmd.lookup |=> !req_tready && !cmd.sweep)
      else $error("lookup not followed by update");

endmodule

/* tb/rate_limit_checker.sv */
`timescale 1ns / 1ps

module rate_limit_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [63:0] req_tdata,  // [31:0] source_ip, [63:32] score
   input  logic [1:0]  req_tuser,  // [1:0] kind
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [7:0]  rsp_tdata,  // [0] limited, [1] table_full, [2] cleared
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_data,
   output int unsigned mismatches,
   output int unsigned pending
);
   import psrl_pkg::*;

   typedef struct packed {
      logic cleared;
      logic table_full;
      logic limited;
   } verdict_type;

   // shadow copy of the source table
   bit                    slot_used  [SETS*WAYS];
   logic [TAG_W-1:0]      slot_tag   [SETS*WAYS];
   logic [2:0][CNT_W-1:0] slot_count [SETS*WAYS];
   logic [SEC_W-1:0]      seconds;

   // shadow copy of the registers
   logic [7:0]  post_base;
   logic [4:0]  post_shift;
   logic [7:0]  comment_base;
   logic [4:0]  comment_shift;
   logic [2:0]  message_limit;
   logic [15:0] window_seconds;

   verdict_type verdicts_due [$];
   int unsigned responses_seen;

   task automatic flag_mismatch(string what);
      $display("[%0t] response %0d: %s", $time, responses_seen, what);
      mismatches++;
   endtask

   // base plus score scaled down by a power of two, rounded toward zero
   function automatic longint allowance(logic [7:0] base, logic [4:0] shift,
                                        logic [31:0] score);
      longint scaled;
      scaled = longint'($signed(score)) / (longint'(1) << shift);
      return longint'(base) + scaled;
   endfunction

   // outcome of one transaction, updating the shadow table
   function automatic verdict_type judge_item(kind_type kind, logic [IP_W-1:0] ip,
                                              logic [31:0] score);
      verdict_type      v;
      int               base_slot;
      int               slot;
      logic [TAG_W-1:0] tag;
      longint           ceiling;
      v = '0;
      if (kind == KIND_TICK) begin
         if (seconds != SEC_MAX) seconds = seconds + 1'b1;
         if (seconds >= window_seconds) begin
            foreach (slot_used[i]) slot_used[i] = 1'b0;
            seconds = '0;
            v.cleared = 1'b1;
         end
         return v;
      end
      tag = ip[IP_W-1:SET_W];
      base_slot = int'(ip[SET_W-1:0]) * WAYS;
      slot = -1;
      // lowest free way, overridden by a tag hit
      for (int w = WAYS - 1; w >= 0; w--) begin
         if (!slot_used[base_slot + w]) slot = base_slot + w;
      end
      for (int w = 0; w < WAYS; w++) begin
         if (slot_used[base_slot + w] && slot_tag[base_slot + w] == tag) begin
            slot = base_slot + w;
         end
      end
      if (slot < 0) begin
         v.limited = 1'b1;
         v.table_full = 1'b1;
         return v;
      end
      if (!slot_used[slot]) begin
         slot_used[slot] = 1'b1;
         slot_tag[slot] = tag;
         slot_count[slot] = '0;
      end
      case (kind)
         KIND_POST:    ceiling = allowance(post_base, post_shift, score);
         KIND_COMMENT: ceiling = allowance(comment_base, comment_shift, score);
         default:      ceiling = longint'(message_limit);
      endcase
      if (longint'(slot_count[slot][int'(kind)]) >= ceiling) begin
         v.limited = 1'b1;
      end else if (slot_count[slot][int'(kind)] != CNT_MAX) begin
         slot_count[slot][int'(kind)] = slot_count[slot][int'(kind)] + 1'b1;
      end
      return v;
   endfunction

   // follow each channel at the rising edge
   always @(posedge clock) begin
      verdict_type want;
      if (reset) begin
         foreach (slot_used[i]) slot_used[i] = 1'b0;
         seconds = '0;
         post_base = POST_BASE_RST;
         post_shift = POST_SHIFT_RST;
         comment_base = COMMENT_BASE_RST;
         comment_shift = COMMENT_SHIFT_RST;
         message_limit = MESSAGE_LIMIT_RST;
         window_seconds = WINDOW_SECONDS_RST;
         verdicts_due.delete();
         responses_seen = 0;
         mismatches = 0;
      end else begin
         // register write
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_POST_BASE:      post_base = csr_data[7:0];
               CSR_POST_SHIFT:     post_shift = csr_data[4:0];
               CSR_COMMENT_BASE:   comment_base = csr_data[7:0];
               CSR_COMMENT_SHIFT:  comment_shift = csr_data[4:0];
               CSR_MESSAGE_LIMIT:  message_limit = csr_data[2:0];
               CSR_WINDOW_SECONDS: window_seconds = csr_data;
               default: ;
            endcase
         end
         // response transaction against the oldest expectation
         if (rsp_tvalid && rsp_tready) begin
            if (verdicts_due.size() == 0) begin
               flag_mismatch("response with no request outstanding");
            end else begin
               want = verdicts_due.pop_front();
               if (rsp_tdata[0] !== want.limited) begin
                  flag_mismatch($sformatf("limited got %b want %b", rsp_tdata[0],
                                          want.limited));
               end
               if (rsp_tdata[1] !== want.table_full) begin
                  flag_mismatch($sformatf("table_full got %b want %b", rsp_tdata[1],
                                          want.table_full));
               end
               if (rsp_tdata[2] !== want.cleared) begin
                  flag_mismatch($sformatf("cleared got %b want %b", rsp_tdata[2],
                                          want.cleared));
               end
               if (rsp_tdata[7:3] !== 5'd0) begin
                  flag_mismatch($sformatf("padding got %b", rsp_tdata[7:3]));
               end
            end
            responses_seen++;
         end
         // request transaction
         if (req_tvalid && req_tready) begin
            verdicts_due.push_back(judge_item(kind_type'(req_tuser), req_tdata[31:0],
                                              req_tdata[63:32]));
         end
      end
      pending = verdicts_due.size();
   end

endmodule

/* tb/tb_per_source_rate_limiter.sv */
`timescale 1ns / 1ps

module tb_per_source_rate_limiter;
   import psrl_pkg::*;

   // indexes past the register list
   localparam logic [2:0] CSR_SPARE_A = 3'd6;
   localparam logic [2:0] CSR_SPARE_B = 3'd7;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata = '0;  // [31:0] source_ip, [63:32] score
   logic [1:0]  req_tuser = KIND_POST;  // [1:0] kind
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;  // [0] limited, [1] table_full, [2] cleared
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [2:0]  csr_index = CSR_POST_BASE;
   logic [15:0] csr_data = '0;

   int unsigned mismatches;
   int unsigned pending;
   bit          steady = 1'b0;

   // addresses reused within a phase so sets fill and counters climb
   logic [SET_W-1:0] set_pool [3];
   logic [TAG_W-1:0] tag_pool [6];

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   per_source_rate_limiter dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   rate_limit_checker verdict_check (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .mismatches (mismatches),
      .pending    (pending)
   );

   // response side backpressure
   always @(negedge clock) begin
      rsp_tready = steady || ($urandom_range(99) >= 12);
   end

   // present one transaction, called just after a falling edge; valid stays high
   task automatic send_item(kind_type kind, logic [31:0] ip, logic [31:0] score);
      while (!steady && $urandom_range(99) < 12) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tuser = kind;
      req_tdata = {score, ip};
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   task automatic write_reg(logic [2:0] index, logic [15:0] data);
      csr_valid = 1'b1;
      csr_index = index;
      csr_data = data;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
   endtask

   // every register, junk above each field narrower than 16 bits, then the spare indexes
   task automatic program_regs(logic [7:0] pb, logic [4:0] ps, logic [7:0] cb,
                               logic [4:0] cs, logic [2:0] ml, logic [15:0] ws);
      write_reg(CSR_POST_BASE, {8'($urandom), pb});
      write_reg(CSR_POST_SHIFT, {11'($urandom), ps});
      write_reg(CSR_COMMENT_BASE, {8'($urandom), cb});
      write_reg(CSR_COMMENT_SHIFT, {11'($urandom), cs});
      write_reg(CSR_MESSAGE_LIMIT, {13'($urandom), ml});
      write_reg(CSR_WINDOW_SECONDS, ws);
      write_reg(CSR_SPARE_A, 16'($urandom));
      write_reg(CSR_SPARE_B, 16'($urandom));
      csr_valid = 1'b0;
   endtask

   task automatic wait_drained();
      req_tvalid = 1'b0;
      while (pending != 0) @(negedge clock);
   endtask

   task automatic refresh_pools();
      set_pool[0] = SET_W'($urandom);
      set_pool[1] = $urandom_range(1) ? '0 : '1;
      set_pool[2] = SET_W'($urandom);
      foreach (tag_pool[i]) tag_pool[i] = TAG_W'($urandom);
      if ($urandom_range(1)) tag_pool[5] = '1;
   endtask

   // small karma for 40 percent, extremes for 20 percent, full range the rest
   function automatic logic [31:0] pick_score();
      int roll;
      roll = $urandom_range(99);
      if (roll < 40) return 32'($urandom_range(1200)) - 32'd600;
      if (roll < 60) begin
         case ($urandom_range(3))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'h0000_0000;
            default: return 32'hFFFF_FFFF;
         endcase
      end
      return $urandom;
   endfunction

   // hot mode drives one source far enough to saturate its post counter
   task automatic send_random(bit hot);
      int          roll;
      kind_type    kind;
      logic [31:0] ip;
      logic [31:0] score;
      roll = $urandom_range(99);
      if (hot) begin
         kind = (roll < 5) ? KIND_TICK : (roll < 88) ? KIND_POST :
                (roll < 94) ? KIND_COMMENT : KIND_MESSAGE;
         ip = ($urandom_range(99) < 95) ? {tag_pool[0], set_pool[0]} : $urandom;
         score = (kind != KIND_POST) ? pick_score() :
                 ($urandom_range(99) < 85) ? 32'h7FFF_FFFF : 32'h0;
      end else begin
         kind = (roll < 10) ? KIND_TICK : (roll < 40) ? KIND_POST :
                (roll < 70) ? KIND_COMMENT : KIND_MESSAGE;
         ip = ($urandom_range(99) < 85) ?
              {tag_pool[$urandom_range(5)], set_pool[$urandom_range(2)]} : $urandom;
         score = pick_score();
      end
      send_item(kind, ip, score);
   endtask

   initial begin
      repeat (12) @(negedge clock);
      reset = 1'b0;

      // reset settings: allowance edges, negative allowance, a full set
      send_item(KIND_POST, 32'h0000_0000, 32'h0);
      send_item(KIND_POST, 32'h0000_0000, 32'h0);
      send_item(KIND_POST, 32'h0000_0000, 32'h0);
      send_item(KIND_POST, 32'h0000_0000, 32'h7FFF_FFFF);
      send_item(KIND_POST, 32'h0000_0000, 32'h8000_0000);
      send_item(KIND_COMMENT, 32'h0000_0000, -32'sd256);
      send_item(KIND_COMMENT, 32'h1234_5400, -32'sd1000);
      send_item(KIND_MESSAGE, 32'h0000_0000, 32'h0);
      send_item(KIND_MESSAGE, 32'hFFFF_FFFF, 32'h0);
      send_item(KIND_MESSAGE, 32'h0000_03FF, 32'h0);
      send_item(KIND_MESSAGE, 32'h0000_07FF, 32'h0);
      send_item(KIND_MESSAGE, 32'h0000_0BFF, 32'h0);
      send_item(KIND_MESSAGE, 32'h0000_0FFF, 32'h0);
      send_item(KIND_TICK, $urandom, $urandom);
      wait_drained();

      // zero window, zero post base and message limit, full comment base, widest shift
      program_regs(8'd0, 5'd0, 8'd255, 5'd31, 3'd0, 16'd0);
      send_item(KIND_TICK, $urandom, $urandom);
      send_item(KIND_MESSAGE, 32'h0000_0FFF, 32'h0);
      send_item(KIND_POST, 32'h0000_0000, 32'h0);
      send_item(KIND_POST, 32'h0000_0000, 32'd5);
      send_item(KIND_COMMENT, 32'h0000_0000, 32'h8000_0000);
      send_item(KIND_COMMENT, 32'h0000_0000, 32'h7FFF_FFFF);
      send_item(KIND_TICK, $urandom, $urandom);
      wait_drained();

      // random phases, each under its own settings
      for (int p = 0; p < 7; p++) begin
         refresh_pools();
         case (p)
            0: program_regs(8'd255, 5'd0, 8'd0, 5'd31, 3'd7, 16'hFFFF);
            1: program_regs(8'd2, 5'd7, 8'd4, 5'd6, 3'd5, 16'd7);
            2: program_regs(8'd0, 5'd31, 8'd255, 5'd0, 3'd0, 16'd1);
            default: program_regs(8'($urandom_range(6)), 5'($urandom_range(31)),
                                  8'($urandom_range(6)), 5'($urandom_range(31)),
                                  3'($urandom), 16'($urandom_range(2, 40)));
         endcase
         steady = (p == 3);
         repeat ((p == 0) ? 360 : 120) send_random(p == 0);
         wait_drained();
         steady = 1'b0;
      end

      repeat (10) @(negedge clock);
      if (mismatches == 0 && pending == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   // run limit
   initial begin
      #20_000_000;
      $display("TEST FAILED");
      $finish;
   end

endmodule

/* filelist.f */
rtl/psrl_pkg.sv
rtl/psrl_ctrl.sv
rtl/psrl_datapath.sv
rtl/per_source_rate_limiter.sv
tb/rate_limit_checker.sv
tb/tb_per_source_rate_limiter.sv
